>>> rtl/nrt_pkg.sv
package nrt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = 7;
   localparam int NONCE_W     = 128;
   localparam int META_W      = 64;

   localparam logic [31:0] TIMEOUT_RESET = 32'd300;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_LOOKUP = 3'd1;
   localparam logic [2:0] OP_CHECK  = 3'd2;
   localparam logic [2:0] OP_TICK   = 3'd3;
   localparam logic [2:0] OP_SWEEP  = 3'd4;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
   localparam logic [2:0] STAT_DUPLICATE = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_REPLAY    = 3'd4;

   typedef struct packed {
      logic [2:0]  operation;
      logic [63:0] nonce_high;
      logic [63:0] nonce_low;
      logic [31:0] nonce_count;
      logic        delete_found;
   } nrt_req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [CNT_W-1:0] entry_count;
      logic [CNT_W-1:0] removed_count;
   } nrt_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } nrt_state_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic finish;
   } nrt_cmd_type;

   typedef struct packed {
      logic last_issue;
   } nrt_sts_type;

endpackage

>>> rtl/nrt_ram.sv
module nrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/nrt_ctrl.sv
module nrt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2:0]          req_op,
   input  nrt_pkg::nrt_sts_type sts,
   output nrt_pkg::nrt_cmd_type cmd,
   output logic                busy
);
   import nrt_pkg::*;

   nrt_state_type state_ff;
   nrt_state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_op == OP_TICK || req_op > OP_SWEEP) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (sts.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd    = '0;
      busy   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SCAN:   cmd.issue  = 1'b1;
         ST_DRAIN:  cmd        = '0;
         ST_FINISH: cmd.finish = 1'b1;
         default:   cmd        = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/nrt_datapath.sv
module nrt_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  nrt_pkg::nrt_cmd_type cmd,
   output nrt_pkg::nrt_sts_type sts,
   input  nrt_pkg::nrt_req_type req_data,
   output logic                 rsp_valid,
   output nrt_pkg::nrt_rsp_type rsp_data,
   input  logic                 csr_write,
   input  logic [31:0]          csr_data
);
   import nrt_pkg::*;

   nrt_req_type      req_ff, req_in;
   logic [IDX_W-1:0] issue_idx_ff, issue_idx_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [31:0]      hit_count_ff, hit_count_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [CNT_W-1:0] removed_ff, removed_in;
   logic             valid_ff [TABLE_DEPTH];
   logic             valid_in [TABLE_DEPTH];
   logic [CNT_W-1:0] total_ff, total_in;
   logic [31:0]      now_ff, now_in;
   logic [31:0]      timeout_ff, timeout_in;
   logic             rsp_valid_ff, rsp_valid_in;
   nrt_rsp_type      rsp_ff, rsp_in;

   logic [NONCE_W-1:0] nonce_rd;
   logic [META_W-1:0]  meta_rd;
   logic               nonce_wr_en;
   logic               meta_wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [META_W-1:0]  meta_wr_data;

   logic        entry_valid;
   logic        key_hit;
   logic [31:0] age;
   logic        expired;
   logic        ins_ok;
   logic        chk_ok;

   assign entry_valid = valid_ff[chk_idx_ff];
   assign key_hit     = chk_vld_ff && entry_valid &&
                        (nonce_rd == {req_ff.nonce_high, req_ff.nonce_low});
   assign age         = now_ff - meta_rd[63:32];
   assign expired     = chk_vld_ff && entry_valid && (req_ff.operation == OP_SWEEP) &&
                        (age > timeout_ff);
   assign ins_ok      = !found_ff && free_found_ff;
   assign chk_ok      = found_ff && (req_ff.nonce_count > hit_count_ff);

   assign sts.last_issue = (issue_idx_ff == IDX_W'(TABLE_DEPTH - 1));

   // RAM writes happen only in the finish cycle
   assign nonce_wr_en  = cmd.finish && (req_ff.operation == OP_INSERT) && ins_ok;
   assign meta_wr_en   = nonce_wr_en ||
                         (cmd.finish && (req_ff.operation == OP_CHECK) && chk_ok);
   assign wr_addr      = (req_ff.operation == OP_INSERT) ? free_idx_ff : hit_idx_ff;
   assign meta_wr_data = (req_ff.operation == OP_INSERT) ? {now_ff, 32'd0}
                                                         : {now_ff, req_ff.nonce_count};

   nrt_ram #(.WIDTH(NONCE_W), .DEPTH(TABLE_DEPTH)) u_nonce_ram (
      .clock   (clock),
      .wr_en   (nonce_wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_ff.nonce_high, req_ff.nonce_low}),
      .rd_addr (issue_idx_ff),
      .rd_data (nonce_rd)
   );

   // stamp in the upper half, last count in the lower half
   nrt_ram #(.WIDTH(META_W), .DEPTH(TABLE_DEPTH)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (wr_addr),
      .wr_data (meta_wr_data),
      .rd_addr (issue_idx_ff),
      .rd_data (meta_rd)
   );

   always_comb begin
      req_in        = req_ff;
      issue_idx_in  = issue_idx_ff;
      chk_vld_in    = cmd.issue;
      chk_idx_in    = issue_idx_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_count_in  = hit_count_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      removed_in    = removed_ff;
      valid_in      = valid_ff;
      total_in      = total_ff;
      now_in        = now_ff;
      timeout_in    = timeout_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;

      if (csr_write) begin
         timeout_in = csr_data;
      end

      if (cmd.load) begin
         req_in        = req_data;
         issue_idx_in  = '0;
         found_in      = 1'b0;
         free_found_in = 1'b0;
         removed_in    = '0;
      end

      if (cmd.issue) begin
         issue_idx_in = issue_idx_ff + IDX_W'(1);
      end

      // compare stage, one entry per cycle
      if (key_hit && !found_ff) begin
         found_in     = 1'b1;
         hit_idx_in   = chk_idx_ff;
         hit_count_in = meta_rd[31:0];
      end
      if (chk_vld_ff && !entry_valid && !free_found_ff) begin
         free_found_in = 1'b1;
         free_idx_in   = chk_idx_ff;
      end
      if (expired) begin
         valid_in[chk_idx_ff] = 1'b0;
         removed_in           = removed_ff + CNT_W'(1);
      end

      if (cmd.finish) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = STAT_OK;
         rsp_in.removed_count = '0;
         unique case (req_ff.operation)
            OP_INSERT: begin
               if (found_ff) begin
                  rsp_in.status = STAT_DUPLICATE;
               end else if (free_found_ff) begin
                  valid_in[free_idx_ff] = 1'b1;
                  total_in              = total_ff + CNT_W'(1);
               end else begin
                  rsp_in.status = STAT_FULL;
               end
            end
            OP_LOOKUP: begin
               if (!found_ff) begin
                  rsp_in.status = STAT_NOT_FOUND;
               end else if (req_ff.delete_found) begin
                  valid_in[hit_idx_ff] = 1'b0;
                  total_in             = total_ff - CNT_W'(1);
                  rsp_in.removed_count = CNT_W'(1);
               end
            end
            OP_CHECK: begin
               if (!found_ff) begin
                  rsp_in.status = STAT_NOT_FOUND;
               end else if (!chk_ok) begin
                  rsp_in.status = STAT_REPLAY;
               end
            end
            OP_TICK: begin
               now_in = now_ff + 32'd1;
            end
            OP_SWEEP: begin
               total_in             = total_ff - removed_ff;
               rsp_in.removed_count = removed_ff;
            end
            default: begin
               rsp_in.status = STAT_OK;
            end
         endcase
         rsp_in.entry_count = total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_vld_ff   <= 1'b0;
         total_ff     <= '0;
         now_ff       <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         chk_vld_ff   <= chk_vld_in;
         total_ff     <= total_in;
         now_ff       <= now_in;
         timeout_ff   <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      issue_idx_ff  <= issue_idx_in;
      chk_idx_ff    <= chk_idx_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_count_ff  <= hit_count_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      removed_ff    <= removed_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/nonce_replay_table.sv
// Channel   Transfer when           Carries
// request   start & !busy           req_data: operation, nonce, count, delete flag
// response  rsp_valid (one cycle)   rsp_data: status, entry count, removed count
// csr       csr_valid & csr_ready   csr_data: timeout in ticks
//
// Insert, lookup, check and sweep scan all table entries through the RAM read
// port, one per cycle, then pass drain and finish. Tick and unused codes go
// straight from idle to finish. busy drops in the cycle the response shows,
// so a new request may be taken then. Synchronous reset clears the valid bits
// and counters and sets timeout to 300; the response cannot be held off.
module nonce_replay_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  nrt_pkg::nrt_req_type req_data,
   output logic                 rsp_valid,
   output nrt_pkg::nrt_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [31:0]          csr_data
);
   import nrt_pkg::*;

   nrt_cmd_type cmd;
   nrt_sts_type sts;

   assign csr_ready = 1'b1;

   nrt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_data.operation),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy)
   );

   nrt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid & csr_ready),
      .csr_data  (csr_data)
   );

endmodule
